// ----- sv/xfp_pkg.sv -----
// Shared types and character constants for the XOR-checked frame parser.
package xfp_pkg;

	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_NOTARGET = 8'h58;

	localparam logic [5:0]  BODY_LIMIT     = 6'd62;
	localparam logic [5:0]  BODY_COUNT_MAX = 6'd63;
	localparam logic [15:0] AGE_MAX        = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd200;
	localparam logic [5:0]  MAX_BODY_RESET = 6'd47;

	localparam int CFG_W = 16;

	typedef enum logic [0:0] {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		REG_TIMEOUT  = 1'b0,
		REG_MAX_BODY = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_GOOD = 2'd1,
		EV_BAD  = 2'd2
	} event_t;

	typedef struct packed {
		logic [31:0] errors;
		logic [31:0] good;
		logic        stale;
		logic        valid;
		logic [7:0]  ttype;
	} status_t;

endpackage

// ----- sv/xfp_frame.sv -----
// Frame parser: hunts for dollar, folds body XOR, collects hex checksum, grades the frame.
module xfp_frame (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [7:0]      byte_value,
	input  logic [5:0]      max_body_len,
	output xfp_pkg::event_t ev,
	output logic [7:0]      first_char
);
	import xfp_pkg::*;

	typedef enum logic [1:0] {
		PH_BODY = 2'd0,
		PH_STAR = 2'd1,
		PH_ONE  = 2'd2,
		PH_TWO  = 2'd3
	} phase_t;

	logic       in_frame_q;
	phase_t     phase_q;
	logic [7:0] xor_q;
	logic [5:0] count_q;
	logic [7:0] first_q;
	logic [7:0] hex_q;
	logic       stopped_q;

	logic       dig_ok;
	logic [3:0] dig_val;
	logic [5:0] limit;
	logic       len_ok;
	logic       is_dollar, is_nl, is_star;

	always_comb begin
		dig_ok  = 1'b1;
		dig_val = 4'd0;
		if (byte_value >= 8'h30 && byte_value <= 8'h39) begin
			dig_val = 4'(byte_value - 8'h30);
		end else if (byte_value >= 8'h41 && byte_value <= 8'h46) begin
			dig_val = 4'(byte_value - 8'h37);
		end else if (byte_value >= 8'h61 && byte_value <= 8'h66) begin
			dig_val = 4'(byte_value - 8'h57);
		end else begin
			dig_ok = 1'b0;
		end
	end

	assign is_dollar = (byte_value == CH_DOLLAR);
	assign is_nl     = (byte_value == CH_NEWLINE);
	assign is_star   = (byte_value == CH_STAR);
	assign limit     = (max_body_len > BODY_LIMIT) ? BODY_LIMIT : max_body_len;
	assign len_ok    = (count_q != 6'd0) && (count_q <= limit);

	// grade only on the newline that closes a frame with at least one digit
	always_comb begin
		ev = EV_NONE;
		if (en && in_frame_q && is_nl && phase_q[1] && len_ok) begin
			ev = (xor_q == hex_q) ? EV_GOOD : EV_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			phase_q    <= PH_BODY;
			xor_q      <= '0;
			count_q    <= '0;
			first_q    <= '0;
			hex_q      <= '0;
			stopped_q  <= 1'b0;
		end else if (en) begin
			if (!in_frame_q) begin
				if (is_dollar) begin
					in_frame_q <= 1'b1;
					phase_q    <= PH_BODY;
					xor_q      <= '0;
					count_q    <= '0;
					first_q    <= '0;
					hex_q      <= '0;
					stopped_q  <= 1'b0;
				end
			end else if (is_nl) begin
				in_frame_q <= 1'b0;
			end else if (phase_q == PH_BODY) begin
				if (is_star) begin
					phase_q <= PH_STAR;
				end else begin
					if (count_q == 6'd0) first_q <= byte_value;
					xor_q <= xor_q ^ byte_value;
					if (count_q != BODY_COUNT_MAX) count_q <= count_q + 6'd1;
				end
			end else if (!stopped_q && phase_q != PH_TWO) begin
				if (!dig_ok) begin
					stopped_q <= 1'b1;
				end else begin
					hex_q   <= {hex_q[3:0], dig_val};
					phase_q <= phase_t'(phase_q + 2'd1);
				end
			end
		end
	end

	// still holds the current frame's first body byte on its closing newline
	assign first_char = first_q;

endmodule

// ----- sv/xfp_status.sv -----
// Latched target, age counter and frame counters; presents the post-beat status.
module xfp_status (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             is_tick,
	input  xfp_pkg::event_t  ev,
	input  logic [7:0]       first_char,
	input  logic [15:0]      timeout_ms,
	output xfp_pkg::status_t nxt
);
	import xfp_pkg::*;

	logic [7:0]  type_q, type_d;
	logic        valid_q, valid_d;
	logic [15:0] age_q, age_d;
	logic        ever_q, ever_d;
	logic [31:0] ok_q, ok_d;
	logic [31:0] err_q, err_d;

	always_comb begin
		type_d  = type_q;
		valid_d = valid_q;
		age_d   = age_q;
		ever_d  = ever_q;
		ok_d    = ok_q;
		err_d   = err_q;
		if (en) begin
			if (is_tick) begin
				if (age_q != AGE_MAX) age_d = age_q + 16'd1;
			end else if (ev == EV_GOOD) begin
				type_d  = first_char;
				valid_d = (first_char != CH_NOTARGET);
				age_d   = '0;
				ever_d  = 1'b1;
				ok_d    = ok_q + 32'd1;
			end else if (ev == EV_BAD) begin
				err_d = err_q + 32'd1;
			end
		end
		nxt.ttype  = type_d;
		nxt.valid  = valid_d;
		nxt.stale  = !ever_d || (age_d > timeout_ms);
		nxt.good   = ok_d;
		nxt.errors = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q  <= CH_NOTARGET;
			valid_q <= 1'b0;
			age_q   <= '0;
			ever_q  <= 1'b0;
			ok_q    <= '0;
			err_q   <= '0;
		end else begin
			type_q  <= type_d;
			valid_q <= valid_d;
			age_q   <= age_d;
			ever_q  <= ever_d;
			ok_q    <= ok_d;
			err_q   <= err_d;
		end
	end

	a_valid_matches_type: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q == (type_q != CH_NOTARGET))
		else $error("target valid flag disagrees with latched type");

	a_err_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !is_tick && ev == EV_BAD) |=> (err_q == $past(err_q) + 32'd1))
		else $error("checksum error count did not advance");

	a_good_clears_age: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !is_tick && ev == EV_GOOD) |=> (age_q == 16'd0 && ever_q))
		else $error("good frame did not refresh age");

endmodule

// ----- sv/xor_checked_frame_parser_unit.sv -----
// Top level: input beat register, parser and status update, result register.
//
//  channel  direction  beat fields (low bit up)
//  s_axis   in         tuser: op ; tdata: byte_value
//  m_axis   out        tuser: event_res ; tdata: target_type, target_valid,
//                      stale, good_frames, checksum_errors, zero fill
//  cfg      in         cfg_addr 0 timeout_ms, 1 max_body_len
//
// One beat per cycle sustained while m_tready is high; each beat passes through
// the input register and then lands in the result register.
// The parse and status update of a beat happens as it leaves the input register.
// Reset clears all parser and status state; no clearing pass.
// A stall holds both full registers; s_tready drops only when both are full.
module xor_checked_frame_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [7:0] target_type, [8] target_valid, [9] stale,
	                               // [41:10] good_frames, [73:42] checksum_errors
	output logic [1:0]  m_tuser,   // [1:0] event_res
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import xfp_pkg::*;

	logic [15:0] timeout_q;
	logic [5:0]  max_body_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        op_s1;
	logic        valid_s2;
	event_t      ev_s2;
	status_t     stat_s2;

	logic        adv, en;
	event_t      ev;
	status_t     stat_nxt;
	logic [7:0]  first_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RESET;
			max_body_q <= MAX_BODY_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_TIMEOUT:  timeout_q  <= cfg_wdata;
				REG_MAX_BODY: max_body_q <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	assign adv      = !valid_s2 || m_tready;
	assign en       = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			op_s1    <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			byte_s1  <= s_tdata;
			op_s1    <= s_tuser;
		end
	end

	xfp_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en && op_s1 == OP_BYTE),
		.byte_value   (byte_s1),
		.max_body_len (max_body_q),
		.ev           (ev),
		.first_char   (first_char)
	);

	xfp_status u_status (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.is_tick    (op_s1 == OP_TICK),
		.ev         (ev),
		.first_char (first_char),
		.timeout_ms (timeout_q),
		.nxt        (stat_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			ev_s2    <= EV_NONE;
			stat_s2  <= '{errors: '0, good: '0, stale: 1'b1, valid: 1'b0,
			              ttype: CH_NOTARGET};
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				ev_s2   <= ev;
				stat_s2 <= stat_nxt;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = ev_s2;
	assign m_tdata  = {6'd0, stat_s2.errors, stat_s2.good, stat_s2.stale,
	                   stat_s2.valid, stat_s2.ttype};

	a_good_not_stale: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ev_s2 == EV_GOOD) |-> !stat_s2.stale)
		else $error("good frame reported as stale");

	a_beat_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> valid_s2)
		else $error("processed beat did not reach result register");

	a_good_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ev == EV_GOOD) |=> (stat_s2.good == $past(stat_s2.good) + 32'd1))
		else $error("good frame count did not advance");

endmodule
